// ===== hdl/lrce_pkg.sv =====
// Shared constants and types for the linear resampler with channel expansion.
// No dependencies; every other file of the block imports this package.
package lrce_pkg;

	// Sample and phase widths (phase is 5.16 fixed point, 21 bits stored)
	localparam int SAMPLE_W   = 16;
	localparam int FRAC_W     = 16;
	localparam int PHASE_W    = 21;
	localparam int CH_CNT_W   = 2;

	// Channel limit of the datapath
	localparam int MAX_CHANNELS = 2;
	localparam int CH_LIMIT     = (MAX_CHANNELS < 2) ? MAX_CHANNELS : 2;

	// Results produced from one input frame at most
	localparam int OUT_LIMIT = 16;
	localparam int CNT_W     = $clog2(OUT_LIMIT);

	// Reset values of the configuration registers
	localparam logic [PHASE_W-1:0]  PHASE_STEP_RST = PHASE_W'(65536);
	localparam logic [CH_CNT_W-1:0] CH_CNT_RST     = CH_CNT_W'(2);

	// Configuration register indexes
	localparam int CFG_IDX_W = 2;
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PHASE_STEP = 2'd0,
		CFG_SOURCE_CH  = 2'd1,
		CFG_DEVICE_CH  = 2'd2
	} cfg_index_t;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic [PHASE_W-1:0]         phase_t;

endpackage

// ===== hdl/lrce_sample_if.sv =====
// Input channel: one source frame of two signed samples with valid/ready.
// Depends on lrce_pkg.
interface lrce_sample_if;
	import lrce_pkg::*;

	logic    valid;
	logic    ready;
	sample_t sample_first;
	sample_t sample_second;

	modport source (output valid, output sample_first, output sample_second, input ready);
	modport sink   (input valid, input sample_first, input sample_second, output ready);
endinterface

// ===== hdl/lrce_frame_if.sv =====
// Output channel: one device frame plus end-of-run flag with valid/ready.
// Depends on lrce_pkg.
interface lrce_frame_if;
	import lrce_pkg::*;

	logic    valid;
	logic    ready;
	sample_t out_first;
	sample_t out_second;
	logic    run_end;

	modport source (output valid, output out_first, output out_second, output run_end,
		input ready);
	modport sink   (input valid, input out_first, input out_second, input run_end,
		output ready);
endinterface

// ===== hdl/lrce_cfg_if.sv =====
// Configuration write channel: register index and write data with valid/ready.
// Depends on lrce_pkg.
interface lrce_cfg_if;
	import lrce_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [PHASE_W-1:0]   data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/lrce_lerp_mul.sv =====
// Shared interpolation multiplier: registered (diff * frac) >>> 16, low 16 bits.
// Depends on lrce_pkg.
module lrce_lerp_mul (
	input  logic                           clk,
	input  logic                           en,
	input  logic signed [lrce_pkg::SAMPLE_W:0] diff,
	input  logic [lrce_pkg::FRAC_W-1:0]    frac,
	output logic [lrce_pkg::SAMPLE_W-1:0]  step_q
);
	import lrce_pkg::*;

	localparam int PROD_W = SAMPLE_W + 1 + FRAC_W + 1;

	logic signed [FRAC_W:0]   frac_s;
	logic signed [PROD_W-1:0] prod;

	// 17x17 signed product; frac is zero-extended so it stays positive
	assign frac_s = $signed({1'b0, frac});
	assign prod   = diff * frac_s;

	// Arithmetic shift by the fraction width; only the sample width survives
	always_ff @(posedge clk) begin
		if (en) begin
			step_q <= prod[FRAC_W +: SAMPLE_W];
		end
	end
endmodule

// ===== hdl/linear_resampler_channel_expand_core.sv =====
// Linear-interpolating sample-rate converter with mono/stereo channel expansion.
// Depends on lrce_pkg, lrce_sample_if, lrce_frame_if, lrce_cfg_if, lrce_lerp_mul.
//
// Usage:
//   cfg     : register writes (phase_step, source_channels, device_channels);
//             always ready, write only while the block is idle.
//   samples : source frames in; ready only while the sequencer is idle.
//   frames  : device frames out, interpolated between the previous and the
//             current source frame; run_end marks the last frame of an input.
// Timing:
//   The first frame after reset only primes the previous-frame register. A
//   frame with phase at or above one period gives no output. Otherwise an
//   input yields n frames (n up to 16): each frame uses the one shared
//   multiplier twice (channel 0, channel 1) and then an emit step.
//   An output register holds each frame; if the receiver stalls, the emit
//   step waits until the register is free. The last frame may still be
//   waiting while the next input is accepted.
// Reset:
//   arst_n clears the phase, previous frame and primed flag, and restores
//   the configuration to a 1:1 step with stereo source and device.
module linear_resampler_channel_expand_core (
	input  logic          clk,
	input  logic          arst_n,
	lrce_cfg_if.sink      cfg,
	lrce_sample_if.sink   samples,
	lrce_frame_if.source  frames
);
	import lrce_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_MUL0,
		S_MUL1,
		S_EMIT
	} state_t;

	localparam logic [PHASE_W:0] PERIOD = (PHASE_W+1)'(65536);

	state_t                state_q;
	logic [PHASE_W-1:0]    phase_step_q;
	logic [CH_CNT_W-1:0]   source_ch_q;
	logic [CH_CNT_W-1:0]   device_ch_q;
	phase_t                phase_q;
	logic                  primed_q;
	sample_t               prev0_q, prev1_q;
	sample_t               cur0_q, cur1_q;
	sample_t               o0_q;
	logic [CNT_W-1:0]      count_q;
	logic                  out_valid_q;
	sample_t               out_first_q, out_second_q;
	logic                  run_end_q;

	logic                  stereo_src, stereo_dev;
	logic                  in_xfer, out_xfer, out_load;
	logic [PHASE_W:0]      phase_next;
	logic                  run_last;
	logic signed [SAMPLE_W:0] mul_diff;
	logic                  mul_en;
	logic [SAMPLE_W-1:0]   mul_step_q;
	sample_t               o1;

	// Clamped channel modes
	assign stereo_src = (CH_LIMIT >= 2) && (source_ch_q >= CH_CNT_W'(2));
	assign stereo_dev = (CH_LIMIT >= 2) && (device_ch_q >= CH_CNT_W'(2));

	// Handshakes
	assign cfg.ready     = 1'b1;
	assign samples.ready = (state_q == S_IDLE);
	assign in_xfer       = samples.valid && (state_q == S_IDLE);
	assign out_xfer      = out_valid_q && frames.ready;
	assign out_load      = (state_q == S_EMIT) && (!out_valid_q || frames.ready);

	// Shared multiplier operand select: channel 0 then channel 1
	always_comb begin
		if (state_q == S_MUL1) begin
			mul_diff = $signed({cur1_q[SAMPLE_W-1], cur1_q}) -
				$signed({prev1_q[SAMPLE_W-1], prev1_q});
		end else begin
			mul_diff = $signed({cur0_q[SAMPLE_W-1], cur0_q}) -
				$signed({prev0_q[SAMPLE_W-1], prev0_q});
		end
	end
	assign mul_en = (state_q == S_MUL0) || (state_q == S_MUL1);

	lrce_lerp_mul u_mul (
		.clk    (clk),
		.en     (mul_en),
		.diff   (mul_diff),
		.frac   (phase_q[FRAC_W-1:0]),
		.step_q (mul_step_q)
	);

	// Channel 1 result: interpolated, duplicated from channel 0, or zero
	always_comb begin
		if (!stereo_dev) begin
			o1 = '0;
		end else if (stereo_src) begin
			o1 = prev1_q + mul_step_q;
		end else begin
			o1 = o0_q;
		end
	end

	// Phase advance and end-of-run test
	assign phase_next = {1'b0, phase_q} + {1'b0, phase_step_q};
	assign run_last   = (phase_next >= PERIOD) || (count_q == CNT_W'(OUT_LIMIT - 1));

	// Sequencer, state and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			phase_step_q <= PHASE_STEP_RST;
			source_ch_q  <= CH_CNT_RST;
			device_ch_q  <= CH_CNT_RST;
			phase_q      <= '0;
			primed_q     <= 1'b0;
			prev0_q      <= '0;
			prev1_q      <= '0;
			cur0_q       <= '0;
			cur1_q       <= '0;
			o0_q         <= '0;
			count_q      <= '0;
			out_valid_q  <= 1'b0;
			out_first_q  <= '0;
			out_second_q <= '0;
			run_end_q    <= 1'b0;
		end else begin
			// Configuration writes; unknown indexes are dropped
			if (cfg.valid) begin
				case (cfg.index)
					CFG_PHASE_STEP: phase_step_q <= cfg.data;
					CFG_SOURCE_CH:  source_ch_q  <= cfg.data[CH_CNT_W-1:0];
					CFG_DEVICE_CH:  device_ch_q  <= cfg.data[CH_CNT_W-1:0];
					default: ;
				endcase
			end

			// Output register drains on transfer
			if (out_xfer && !out_load) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						if (!primed_q) begin
							prev0_q  <= samples.sample_first;
							prev1_q  <= samples.sample_second;
							primed_q <= 1'b1;
						end else if (phase_q[PHASE_W-1:FRAC_W] != '0) begin
							// Phase past this period: store frame, no output
							phase_q <= PHASE_W'({1'b0, phase_q} - PERIOD);
							prev0_q <= samples.sample_first;
							prev1_q <= samples.sample_second;
						end else begin
							cur0_q  <= samples.sample_first;
							cur1_q  <= samples.sample_second;
							count_q <= '0;
							state_q <= S_MUL0;
						end
					end
				end
				S_MUL0: begin
					state_q <= S_MUL1;
				end
				S_MUL1: begin
					o0_q    <= prev0_q + mul_step_q;
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (out_load) begin
						out_valid_q  <= 1'b1;
						out_first_q  <= o0_q;
						out_second_q <= o1;
						run_end_q    <= run_last;
						count_q      <= count_q + CNT_W'(1);
						if (run_last) begin
							// Close the run: drop one period, or clear the phase when the output cap ends it
							if (phase_next >= PERIOD) begin
								phase_q <= PHASE_W'(phase_next - PERIOD);
							end else begin
								phase_q <= '0;
							end
							prev0_q <= cur0_q;
							prev1_q <= cur1_q;
							state_q <= S_IDLE;
						end else begin
							phase_q <= PHASE_W'(phase_next);
							state_q <= S_MUL0;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign frames.valid      = out_valid_q;
	assign frames.out_first  = out_first_q;
	assign frames.out_second = out_second_q;
	assign frames.run_end    = run_end_q;
endmodule

// ===== sim/lrce_checker.sv =====
// Scoreboard for the linear resampler: watches the config, sample and frame channels,
// predicts device frames and compares them. Depends on lrce_pkg and the lrce_*_if interfaces.
`timescale 1ns / 1ps

module lrce_checker (
	input  logic   clk,
	input  logic   arst_n,
	lrce_cfg_if    cfg,
	lrce_sample_if samples,
	lrce_frame_if  frames,
	output int     fail_count,
	output int     frames_checked,
	output int     outstanding
);
	import lrce_pkg::*;

	localparam int unsigned PERIOD = 1 << FRAC_W;

	typedef struct packed {
		sample_t first;
		sample_t second;
		logic    run_end;
	} dev_frame_t;

	// Shadow of the configuration registers
	phase_t              step_q;
	logic [CH_CNT_W-1:0] src_cnt_q;
	logic [CH_CNT_W-1:0] dev_cnt_q;

	// Shadow of the resampler state
	sample_t prev_first_q;
	sample_t prev_second_q;
	phase_t  phase_q;
	logic    primed_q;

	dev_frame_t frames_due[$];

	// Zero counts act as one, counts above the datapath limit saturate
	function automatic int unsigned eff_channels(logic [CH_CNT_W-1:0] n);
		if (n == 0)
			return 1;
		if (n > CH_LIMIT)
			return CH_LIMIT;
		return n;
	endfunction

	// prev + floor((cur - prev) * frac / 2^16)
	function automatic sample_t interp(sample_t prev, sample_t cur, logic [FRAC_W-1:0] frac);
		longint prod;
		prod = (longint'(cur) - longint'(prev)) * longint'(frac);
		return sample_t'(longint'(prev) + (prod >>> FRAC_W));
	endfunction

	// Expand one source frame into the device frames it produces
	task automatic resample_frame(sample_t cur_first, sample_t cur_second);
		int unsigned acc;
		int unsigned src_n;
		int unsigned dev_n;
		int          n;
		dev_frame_t  f;
		if (!primed_q) begin
			prev_first_q  = cur_first;
			prev_second_q = cur_second;
			primed_q      = 1'b1;
			return;
		end
		src_n = eff_channels(src_cnt_q);
		dev_n = eff_channels(dev_cnt_q);
		acc   = phase_q;
		n     = 0;
		while (acc < PERIOD && n < OUT_LIMIT) begin
			f.first  = interp(prev_first_q, cur_first, acc[FRAC_W-1:0]);
			f.second = '0;
			if (dev_n >= 2)
				f.second = (src_n >= 2) ?
					interp(prev_second_q, cur_second, acc[FRAC_W-1:0]) : f.first;
			// last of the run: next phase leaves the period or the output cap is hit
			f.run_end = ((acc + step_q) >= PERIOD) || (n == OUT_LIMIT - 1);
			frames_due.push_back(f);
			n++;
			acc += step_q;
		end
		phase_q       = (acc >= PERIOD) ? phase_t'(acc - PERIOD) : '0;
		prev_first_q  = cur_first;
		prev_second_q = cur_second;
	endtask

	// Compare one device frame transfer against the oldest prediction
	task automatic check_frame();
		dev_frame_t want;
		if (frames_due.size() == 0) begin
			$error("unexpected device frame: out_first %0d out_second %0d run_end %0b",
				frames.out_first, frames.out_second, frames.run_end);
			fail_count++;
			return;
		end
		want = frames_due.pop_front();
		frames_checked++;
		if (frames.out_first !== want.first) begin
			$error("out_first: expected %0d, got %0d", want.first, frames.out_first);
			fail_count++;
		end
		if (frames.out_second !== want.second) begin
			$error("out_second: expected %0d, got %0d", want.second, frames.out_second);
			fail_count++;
		end
		if (frames.run_end !== want.run_end) begin
			$error("run_end: expected %0b, got %0b", want.run_end, frames.run_end);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q         = PHASE_STEP_RST;
			src_cnt_q      = CH_CNT_RST;
			dev_cnt_q      = CH_CNT_RST;
			prev_first_q   = '0;
			prev_second_q  = '0;
			phase_q        = '0;
			primed_q       = 1'b0;
			fail_count     = 0;
			frames_checked = 0;
			frames_due.delete();
			outstanding   <= 0;
		end else begin
			// register write
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					CFG_PHASE_STEP: step_q    = cfg.data;
					CFG_SOURCE_CH:  src_cnt_q = cfg.data[CH_CNT_W-1:0];
					CFG_DEVICE_CH:  dev_cnt_q = cfg.data[CH_CNT_W-1:0];
					default: ;
				endcase
			end
			// an output transfer at this edge belongs to an earlier input
			if (frames.valid && frames.ready)
				check_frame();
			if (samples.valid && samples.ready)
				resample_frame(samples.sample_first, samples.sample_second);
			outstanding <= frames_due.size();
		end
	end

endmodule

// ===== sim/linear_resampler_channel_expand_core_tb.sv =====
// Top of the resampler testbench: clock, reset, stimulus, stall patterns and verdict.
// Depends on lrce_pkg, the lrce_*_if interfaces, lrce_checker and the core.
`timescale 1ns / 1ps

module linear_resampler_channel_expand_core_tb;
	import lrce_pkg::*;

	localparam int CYCLE_LIMIT     = 1000000;
	localparam int SETTLE_CYCLES   = 1 + 3 * OUT_LIMIT;
	localparam int RAND_PHASES     = 6;
	localparam int ITEMS_PER_PHASE = 25;

	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;

	localparam sample_t S_MAX  = 16'sh7FFF;
	localparam sample_t S_MIN  = 16'sh8000;
	localparam sample_t S_ZERO = 16'sh0000;
	localparam sample_t S_NEG1 = 16'shFFFF;
	localparam sample_t S_ONE  = 16'sh0001;

	localparam phase_t STEP_LOW  = 21'd4096;
	localparam phase_t STEP_HIGH = 21'd1048576;
	localparam phase_t STEP_FULL = 21'h1FFFFF;
	localparam phase_t STEP_UNIT = 21'd65536;

	logic clk;
	logic arst_n;
	logic calm;
	int   fail_count;
	int   frames_checked;
	int   outstanding;
	int   frames_sent;
	int   settings_used;
	int   cycles;

	lrce_cfg_if    cfg_bus ();
	lrce_sample_if sample_bus ();
	lrce_frame_if  frame_bus ();

	linear_resampler_channel_expand_core u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_bus),
		.samples (sample_bus),
		.frames  (frame_bus)
	);

	lrce_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_bus),
		.samples        (sample_bus),
		.frames         (frame_bus),
		.fail_count     (fail_count),
		.frames_checked (frames_checked),
		.outstanding    (outstanding)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Mostly back to back, some short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic sample_t pick_sample();
		case ($urandom_range(0, 9))
			0: return S_MAX;
			1: return S_MIN;
			2: return S_ZERO;
			3: return S_NEG1;
			default: return sample_t'($urandom);
		endcase
	endfunction

	function automatic phase_t pick_step();
		case ($urandom_range(0, 9))
			0: return STEP_LOW;
			1: return STEP_HIGH;
			2: return phase_t'($urandom_range(0, STEP_LOW - 1));
			3: return STEP_FULL;
			4, 5: return phase_t'($urandom_range(131072, STEP_HIGH));
			default: return phase_t'($urandom_range(STEP_LOW, 131072));
		endcase
	endfunction

	// Channel count word, sometimes with junk in the unused upper bits
	function automatic phase_t pick_count_word();
		phase_t w;
		w = phase_t'($urandom_range(0, 3));
		if ($urandom_range(0, 3) == 0)
			w |= phase_t'($urandom) & ~phase_t'(3);
		return w;
	endfunction

	// One source frame transfer; valid stays up when the next call follows directly
	task automatic send_frame(sample_t first, sample_t second);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			sample_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_bus.valid         <= 1'b1;
		sample_bus.sample_first  <= first;
		sample_bus.sample_second <= second;
		do
			@(posedge clk);
		while (!sample_bus.ready);
		frames_sent++;
	endtask

	// Stop sending and let every predicted frame arrive, then let the core settle
	task automatic drain();
		sample_bus.valid <= 1'b0;
		// the pending count covers the last transfer only from the next edge on
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write all registers back to back; optionally also poke the unused index
	task automatic configure(phase_t step, phase_t src_w, phase_t dev_w, bit spare);
		logic [CFG_IDX_W-1:0] idx [4];
		phase_t               val [4];
		int                   n;
		idx[0] = CFG_PHASE_STEP;
		val[0] = step;
		idx[1] = CFG_SOURCE_CH;
		val[1] = src_w;
		idx[2] = CFG_DEVICE_CH;
		val[2] = dev_w;
		idx[3] = CFG_SPARE_IDX;
		val[3] = phase_t'($urandom);
		n = spare ? 4 : 3;
		for (int k = 0; k < n; k++) begin
			cfg_bus.valid <= 1'b1;
			cfg_bus.index <= idx[k];
			cfg_bus.data  <= val[k];
			do
				@(posedge clk);
			while (!cfg_bus.ready);
		end
		cfg_bus.valid <= 1'b0;
		settings_used++;
	endtask

	// Frame receiver: bursts of ready with random stalls, or always ready when calm
	initial begin
		int burst;
		int gap;
		frame_bus.ready <= 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			frame_bus.ready <= 1'b1;
			if (calm) begin
				@(posedge clk);
			end else begin
				burst = $urandom_range(1, 12);
				repeat (burst) @(posedge clk);
				gap = pick_gap();
				if (gap > 0) begin
					frame_bus.ready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
		end
	end

	// Watchdog
	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("TEST FAILED");
		$finish;
	end

	// Stimulus and verdict
	initial begin
		arst_n                   <= 1'b0;
		calm                     <= 1'b1;
		sample_bus.valid         <= 1'b0;
		sample_bus.sample_first  <= '0;
		sample_bus.sample_second <= '0;
		cfg_bus.valid            <= 1'b0;
		cfg_bus.index            <= CFG_PHASE_STEP;
		cfg_bus.data             <= '0;
		frames_sent   = 0;
		settings_used = 1;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: first frame only primes, then 1:1 copies of full-scale swings
		send_frame(S_MAX, S_MIN);
		send_frame(S_MIN, S_MAX);
		send_frame(S_ZERO, S_NEG1);
		send_frame(S_NEG1, S_ZERO);

		// smallest legal step: sixteen outputs across full-scale steps
		drain();
		configure(STEP_LOW, phase_t'(2), phase_t'(2), 1'b0);
		send_frame(S_MIN, S_MAX);
		send_frame(S_MAX, S_MIN);
		send_frame(S_MAX, S_MIN);

		// zero step hits the output cap; stereo source into mono device
		drain();
		calm <= 1'b0;
		configure('0, phase_t'(2), phase_t'(1), 1'b0);
		send_frame(S_MIN, S_MAX);
		send_frame(S_ONE, S_NEG1);

		// step under the minimum with out-of-range counts (mono source duplicated)
		drain();
		configure(phase_t'(1000), phase_t'(0), phase_t'(3), 1'b1);
		send_frame(S_MAX, S_ZERO);
		send_frame(S_MIN, S_MAX);

		// largest step word: one output, then inputs with none
		drain();
		configure(STEP_FULL, phase_t'(3), phase_t'(0), 1'b0);
		send_frame(S_NEG1, S_MAX);
		send_frame(S_MIN, S_MIN);
		send_frame(S_MAX, S_MAX);

		// top of the step range while the phase is still far above one period
		drain();
		configure(STEP_HIGH, phase_t'(1), phase_t'(2), 1'b0);
		send_frame(S_ZERO, S_MAX);
		send_frame(S_MAX, S_ZERO);
		send_frame(S_MIN, S_ONE);

		// settings set back to a 1:1 step with stereo counts before the random phases
		drain();
		configure(STEP_UNIT, phase_t'(2), phase_t'(2), 1'b0);

		// random phases, each with its own settings and stall behavior
		for (int p = 0; p < RAND_PHASES; p++) begin
			if (p > 0) begin
				drain();
				configure(pick_step(), pick_count_word(), pick_count_word(),
					$urandom_range(0, 1));
			end
			calm <= ($urandom_range(0, 2) == 0);
			for (int i = 0; i < ITEMS_PER_PHASE; i++)
				send_frame(pick_sample(), pick_sample());
		end
		drain();

		$display("Checked %0d device frames from %0d source frames under %0d register settings",
			frames_checked, frames_sent, settings_used);
		$display("Steps from zero to full scale, all channel counts, stalls on both sides");
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
